// File: rtl/core/tvbu_pkg.sv
// Package with op codes, tag constants and helper functions for the tagged value unit.
package tvbu_pkg;

  typedef enum logic [2:0] {
    OP_CLASSIFY   = 3'd0,
    OP_BOX_INT    = 3'd1,
    OP_BOX_REAL   = 3'd2,
    OP_UNBOX_REAL = 3'd3,
    OP_UNBOX_INT  = 3'd4
  } op_e;

  localparam logic [63:0] FixBias = 64'h1000_0000_0000_0000;
  localparam logic [63:0] NegBase = 64'hF000_0000_0000_0000;
  localparam logic [63:0] Flo2Tag = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Low60   = 64'h0FFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] PtrSet  = 16'h8001;
  localparam logic [15:0] FixSet  = 16'h6006;
  localparam logic [15:0] FloSet  = 16'h1918;
  localparam logic [15:0] I32Set  = 16'h4002;
  localparam logic [3:0]  TagFlo2 = 4'd8;
  localparam logic [63:0] IntMax  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] IntMin  = 64'h8000_0000_0000_0000;

  // Decoded kind of the operand's tag for unboxing.
  typedef enum logic [2:0] {
    K_UNKNOWN = 3'd0,
    K_FIXPOS  = 3'd1,
    K_FIXNEG  = 3'd2,
    K_FLO1    = 3'd3,
    K_FLO2    = 3'd4
  } kind_e;

  function automatic kind_e kind_of(input logic [3:0] t);
    kind_e k;
    unique case (t)
      4'd1, 4'd2:                 k = K_FIXPOS;
      4'd13, 4'd14:               k = K_FIXNEG;
      4'd3, 4'd4, 4'd11, 4'd12:   k = K_FLO1;
      4'd8:                       k = K_FLO2;
      default:                    k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/core/tagged_value_box_unbox_unit.sv
// Top level of the tagged value box and unbox unit, a four stage pipeline.
//
// Usage: one input channel (valid_i, stall_o, op_i, operand_i) and one result
// channel (valid_o, stall_i and the result fields). Each accepted beat gives
// exactly one result beat, in order. Ops are classify, box_int, box_real,
// unbox_real and unbox_int; codes 5 to 7 give an all-zero result.
// Throughput is one beat per cycle: every stage advances each cycle
// unless the result beat is stalled. The stages are decode and simple
// results; integer magnitude, leading-zero count and normalize shift, plus
// the double to integer shift; rounding and negation; tag flags and output.
// The integer to double conversion counts leading zeros and shifts in stage
// two and rounds in stage three. Double to integer shifts in stage two and
// negates in stage three.
// Reset clears all stage valid bits; no result is pending after reset.
// When stall_i is high the pipeline holds; stall_o rises only when the
// whole pipeline is full and the output is stalled, so bubbles are squeezed
// out and no beat is lost or repeated.
module tagged_value_box_unbox_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [2:0]  op_i,
  input  logic [63:0] operand_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] result_bits_o,
  output logic [3:0]  tag_o,
  output logic        is_pointer_o,
  output logic        is_fixnum_o,
  output logic        is_flonum_o,
  output logic        is_int32_o,
  output logic        range_error_o,
  output logic        unknown_tag_o
);
  import tvbu_pkg::*;

  // Stage enables: a stage advances when it is empty or the next one moves.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  assign en4 = !v4_q || !stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign stall_o = !en1;

  // ---------------- Stage 1: decode and simple results ------------------
  logic [63:0] s1_res_d, s1_word_d, s1_int_d;
  logic        s1_err_d, s1_unk_d, s1_zero_d;
  logic        s1_isreal_d, s1_toint_d, s1_tofloat_d;
  logic [63:0] s1_dbl_d;
  kind_e       kind;
  logic [63:0] iv;

  always_comb begin
    kind = kind_of(operand_i[63:60]);
    iv = (kind == K_FIXPOS) ? operand_i - FixBias : operand_i + FixBias;
    s1_res_d = '0;
    s1_word_d = operand_i;
    s1_err_d = 1'b0;
    s1_unk_d = 1'b0;
    s1_zero_d = 1'b0;
    s1_isreal_d = (kind == K_FLO1) || (kind == K_FLO2);
    s1_toint_d = 1'b0;
    s1_tofloat_d = 1'b0;
    s1_int_d = iv;
    s1_dbl_d = (kind == K_FLO2) ? {operand_i[59:0], 4'd0} : operand_i;
    unique case (op_i)
      OP_CLASSIFY: s1_res_d = operand_i;
      OP_BOX_INT: begin
        s1_err_d = (operand_i[63:61] != {3{operand_i[63]}});
        s1_res_d = operand_i[63] ? NegBase + operand_i : operand_i + FixBias;
        s1_word_d = s1_res_d;
      end
      OP_BOX_REAL: begin
        if (FloSet[operand_i[63:60]] && operand_i[63:60] != TagFlo2) begin
          s1_res_d = operand_i;
        end else begin
          s1_res_d = (((operand_i + 64'd8) >> 4) & Low60) | Flo2Tag;
        end
        s1_word_d = s1_res_d;
      end
      OP_UNBOX_REAL, OP_UNBOX_INT: begin
        if (kind == K_UNKNOWN) begin
          s1_unk_d = 1'b1;
        end else if (op_i == OP_UNBOX_REAL) begin
          if (s1_isreal_d) s1_res_d = s1_dbl_d;
          else s1_tofloat_d = 1'b1;
        end else begin
          if (s1_isreal_d) s1_toint_d = 1'b1;
          else s1_res_d = iv;
        end
      end
      default: s1_zero_d = 1'b1;
    endcase
  end

  logic [63:0] s1_res_q, s1_word_q, s1_int_q, s1_dbl_q;
  logic        s1_err_q, s1_unk_q, s1_zero_q, s1_toint_q, s1_tofloat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_res_q <= s1_res_d;
      s1_word_q <= s1_word_d;
      s1_int_q <= s1_int_d;
      s1_dbl_q <= s1_dbl_d;
      s1_err_q <= s1_err_d;
      s1_unk_q <= s1_unk_d;
      s1_zero_q <= s1_zero_d;
      s1_toint_q <= s1_toint_d;
      s1_tofloat_q <= s1_tofloat_d;
    end
  end

  // ---------------- Stage 2: normalize / align -------------------------
  // Int to double: magnitude and leading-zero count, then left shift.
  // Double to int: right shift of the significand by the exponent.
  logic        sgn2;
  logic [63:0] mag2, norm2, fx2;
  logic [6:0]  lz2;
  logic [10:0] exp_in2;
  logic        sat2, nan2, small2;
  logic [11:0] sh2;

  always_comb begin
    sgn2 = s1_int_q[63];
    mag2 = sgn2 ? (~s1_int_q + 64'd1) : s1_int_q;
    lz2 = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (mag2[i]) lz2 = 7'(63 - i);
    end
    norm2 = mag2 << lz2[5:0];
    exp_in2 = s1_dbl_q[62:52];
    nan2 = (exp_in2 == 11'h7FF) && (s1_dbl_q[51:0] != '0);
    // Magnitude 2^63 or more saturates, except exactly -2^63.
    sat2 = !nan2 && (exp_in2 >= 11'd1086) &&
           !(s1_dbl_q[63] && exp_in2 == 11'd1086 && s1_dbl_q[51:0] == '0);
    small2 = exp_in2 < 11'd1023;
    sh2 = 12'd1075 - {1'b0, exp_in2};
    fx2 = '0;
    if (!small2 && !sat2) begin
      if (exp_in2 >= 11'd1075) fx2 = {11'd0, 1'b1, s1_dbl_q[51:0]} << (exp_in2 - 11'd1075);
      else fx2 = {11'd0, 1'b1, s1_dbl_q[51:0]} >> sh2[5:0];
    end
  end

  logic [63:0] s2_res_q, s2_word_q, s2_norm_q, s2_fx_q;
  logic [6:0]  s2_lz_q;
  logic        s2_sgn_q, s2_dsgn_q, s2_sat_q, s2_nan_q;
  logic        s2_err_q, s2_unk_q, s2_zero_q, s2_toint_q, s2_tofloat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_res_q <= s1_res_q;
      s2_word_q <= s1_word_q;
      s2_norm_q <= norm2;
      s2_fx_q <= fx2;
      s2_lz_q <= lz2;
      s2_sgn_q <= sgn2;
      s2_dsgn_q <= s1_dbl_q[63];
      s2_sat_q <= sat2;
      s2_nan_q <= nan2;
      s2_err_q <= s1_err_q;
      s2_unk_q <= s1_unk_q;
      s2_zero_q <= s1_zero_q;
      s2_toint_q <= s1_toint_q;
      s2_tofloat_q <= s1_tofloat_q;
    end
  end

  // ---------------- Stage 3: round / negate -----------------------------
  logic [53:0] mant3;
  logic        rnd3;
  logic [10:0] exp3;
  logic [63:0] fbits3, ibits3, res3;
  logic        err3;

  always_comb begin
    // Round to nearest even on the 53-bit significand.
    rnd3 = s2_norm_q[10] && (s2_norm_q[11] || (s2_norm_q[9:0] != '0));
    mant3 = {1'b0, s2_norm_q[63:11]} + {53'd0, rnd3};
    exp3 = 11'(11'd1086 - {4'd0, s2_lz_q}) + {10'd0, mant3[53]};
    if (s2_lz_q == 7'd64) fbits3 = '0;
    else fbits3 = {s2_sgn_q, exp3, mant3[53] ? mant3[52:1] : mant3[51:0]};
    if (s2_nan_q) ibits3 = '0;
    else if (s2_sat_q) ibits3 = s2_dsgn_q ? IntMin : IntMax;
    else ibits3 = s2_dsgn_q ? (~s2_fx_q + 64'd1) : s2_fx_q;
    res3 = s2_res_q;
    err3 = s2_err_q;
    if (s2_tofloat_q) res3 = fbits3;
    if (s2_toint_q) begin
      res3 = ibits3;
      err3 = s2_nan_q || s2_sat_q;
    end
  end

  logic [63:0] s3_res_q, s3_word_q;
  logic        s3_err_q, s3_unk_q, s3_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_res_q <= res3;
      s3_word_q <= s2_word_q;
      s3_err_q <= err3;
      s3_unk_q <= s2_unk_q;
      s3_zero_q <= s2_zero_q;
    end
  end

  // ---------------- Stage 4: flags and output register ------------------
  logic [3:0] t4;
  logic       i32_4;
  assign t4 = s3_word_q[63:60];
  assign i32_4 = I32Set[t4] && (s3_word_q[59:32] == {28{s3_word_q[31]}});

  logic [63:0] res_q;
  logic [3:0]  tag_q;
  logic        ptr_q, fix_q, flo_q, i32_q, err_q, unk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      if (s3_zero_q) begin
        res_q <= '0; tag_q <= '0; ptr_q <= 1'b0; fix_q <= 1'b0;
        flo_q <= 1'b0; i32_q <= 1'b0; err_q <= 1'b0; unk_q <= 1'b0;
      end else begin
        res_q <= s3_res_q; tag_q <= t4; ptr_q <= PtrSet[t4];
        fix_q <= FixSet[t4]; flo_q <= FloSet[t4]; i32_q <= i32_4;
        err_q <= s3_err_q; unk_q <= s3_unk_q;
      end
    end
  end

  assign valid_o = v4_q;
  assign result_bits_o = res_q;
  assign tag_o = tag_q;
  assign is_pointer_o = ptr_q;
  assign is_fixnum_o = fix_q;
  assign is_flonum_o = flo_q;
  assign is_int32_o = i32_q;
  assign range_error_o = err_q;
  assign unknown_tag_o = unk_q;

  // Checks on the pipeline control and the result flags.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (v1_q && v2_q && v3_q && v4_q && stall_i))
    else $error("input stalled with room in the pipeline");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(result_bits_o)))
    else $error("stalled result changed");
  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $onehot0({is_pointer_o, is_fixnum_o, is_flonum_o}))
    else $error("tag class flags overlap");
  a_unk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && unknown_tag_o) |-> (result_bits_o == '0 && !range_error_o))
    else $error("unknown tag with nonzero result");

endmodule

// File: test/tagged_value_box_unbox_unit_tb.sv
// Testbench for the tagged value box and unbox unit with a self-checking predictor.
module tagged_value_box_unbox_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tvbu_pkg::*;

  typedef struct packed {
    logic [63:0] bits;
    logic [3:0]  tag;
    logic        is_pointer;
    logic        is_fixnum;
    logic        is_flonum;
    logic        is_int32;
    logic        range_error;
    logic        unknown_tag;
  } tv_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [2:0]  op_i = 3'd0;
  logic [63:0] operand_i = 64'd0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [63:0] result_bits_o;
  logic [3:0]  tag_o;
  logic        is_pointer_o, is_fixnum_o, is_flonum_o, is_int32_o;
  logic        range_error_o, unknown_tag_o;

  tv_result_t  pending_results[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  tagged_value_box_unbox_unit uut (.*);

  always #2 clk_i = ~clk_i;

  // Double to integer: truncate toward zero, saturate, and flag NaN.
  function automatic logic [63:0] dbl_to_long(input logic [63:0] d, output logic err);
    logic [10:0]  ex;
    logic [116:0] mag;
    logic [63:0]  val;
    ex = d[62:52];
    err = 1'b0;
    if (ex == 11'h7FF && d[51:0] != 0) begin
      err = 1'b1;
      return 64'd0;
    end
    if (!d[63] && ex >= 11'd1086) begin
      err = 1'b1;
      return IntMax;
    end
    if (d[63] && (ex > 11'd1086 || (ex == 11'd1086 && d[51:0] != 0))) begin
      err = 1'b1;
      return IntMin;
    end
    if (ex < 11'd1023) return 64'd0;
    mag = {64'd0, 1'b1, d[51:0]};
    if (ex >= 11'd1075) mag = mag << (ex - 11'd1075);
    else mag = mag >> (11'd1075 - ex);
    val = mag[63:0];
    return d[63] ? -val : val;
  endfunction

  // Expected result of one op on one operand.
  function automatic tv_result_t box_unbox_predict(input logic [2:0] op, input logic [63:0] x);
    tv_result_t  r;
    logic [63:0] word, res, iv;
    logic [3:0]  t;
    logic        err, unk, isreal;
    logic [63:0] dbits;
    longint      sv;
    real         rv;
    r = '0;
    word = x;
    res = 64'd0;
    err = 1'b0;
    unk = 1'b0;
    isreal = 1'b0;
    iv = 64'd0;
    dbits = 64'd0;
    t = x[63:60];
    case (op)
      OP_CLASSIFY: res = x;
      OP_BOX_INT: begin
        sv = $signed(x);
        if (sv >= 64'sh2000_0000_0000_0000 || sv < -64'sh2000_0000_0000_0000) err = 1'b1;
        res = x[63] ? NegBase + x : x + FixBias;
        word = res;
      end
      OP_BOX_REAL: begin
        if (FloSet[t] && t != TagFlo2) res = x;
        else res = (((x + 64'd8) >> 4) & Low60) | Flo2Tag;
        word = res;
      end
      OP_UNBOX_REAL, OP_UNBOX_INT: begin
        case (kind_of(t))
          K_FIXPOS: iv = x - FixBias;
          K_FIXNEG: iv = x + FixBias;
          K_FLO1: begin
            isreal = 1'b1;
            dbits = x;
          end
          K_FLO2: begin
            isreal = 1'b1;
            dbits = x << 4;
          end
          default: unk = 1'b1;
        endcase
        if (unk) begin
          res = 64'd0;
        end else if (op == OP_UNBOX_REAL) begin
          if (isreal) begin
            res = dbits;
          end else begin
            sv = $signed(iv);
            rv = sv;
            res = $realtobits(rv);
          end
        end else begin
          res = isreal ? dbl_to_long(dbits, err) : iv;
        end
      end
      default: return r;
    endcase
    t = word[63:60];
    r.bits = res;
    r.tag = t;
    r.is_pointer = PtrSet[t];
    r.is_fixnum = FixSet[t];
    r.is_flonum = FloSet[t];
    r.is_int32 = I32Set[t] && (word[59:32] == {28{word[31]}});
    r.range_error = err;
    r.unknown_tag = unk;
    return r;
  endfunction

  // Send one beat, with random idle cycles ahead of it.
  task automatic send_beat(input logic [2:0] op, input logic [63:0] x);
    if ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    valid_i <= 1'b1;
    op_i <= op;
    operand_i <= x;
    do @(posedge clk_i); while (stall_o);
    pending_results.push_back(box_unbox_predict(op, x));
  endtask

  task automatic go_idle();
    valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Compare result beats and drive the random output stall.
  always @(posedge clk_i) begin
    tv_result_t got, want;
    if (rst_ni && valid_o && !stall_i) begin
      got = '{result_bits_o, tag_o, is_pointer_o, is_fixnum_o, is_flonum_o,
              is_int32_o, range_error_o, unknown_tag_o};
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing pending, got %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected bits=%h tag=%h flags=%b got bits=%h tag=%h flags=%b",
                   $time, want.bits, want.tag, want[5:0], got.bits, got.tag, got[5:0]);
          errors++;
        end
      end
    end
    stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic test_classify();
    send_beat(OP_CLASSIFY, 64'h0000_0000_0000_0000);
    send_beat(OP_CLASSIFY, 64'hE000_0000_8000_0000);
  endtask

  // Fixnum range edges on both sides, and the wrap of the extremes.
  task automatic test_box_int();
    send_beat(OP_BOX_INT, 64'h1FFF_FFFF_FFFF_FFFF);
    send_beat(OP_BOX_INT, 64'h2000_0000_0000_0000);
    send_beat(OP_BOX_INT, 64'hE000_0000_0000_0000);
    send_beat(OP_BOX_INT, 64'hDFFF_FFFF_FFFF_FFFF);
    send_beat(OP_BOX_INT, 64'h7FFF_FFFF_FFFF_FFFF);
    send_beat(OP_BOX_INT, 64'h8000_0000_0000_0000);
  endtask

  // Pass-through tag, and the rounding carry that wraps.
  task automatic test_box_real();
    send_beat(OP_BOX_REAL, 64'h3FF8_0000_0000_0000);
    send_beat(OP_BOX_REAL, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Every tag through one of the two unbox ops.
  task automatic test_unbox_tags();
    for (int t = 0; t < 16; t++)
      send_beat((t % 2) ? OP_UNBOX_INT : OP_UNBOX_REAL, {t[3:0], 60'h0_0000_8765_4321});
  endtask

  // Saturation, NaN, exact minimum and truncation of doubles.
  task automatic test_convert();
    send_beat(OP_UNBOX_INT, 64'h87FF_8000_0000_0000);
    send_beat(OP_UNBOX_INT, 64'h43E0_0000_0000_0000);
    send_beat(OP_UNBOX_INT, 64'hC3E0_0000_0000_0000);
    send_beat(OP_UNBOX_INT, 64'hC3E0_0000_0000_0001);
    send_beat(OP_UNBOX_INT, 64'hBFF8_0000_0000_0000);
  endtask

  task automatic test_bad_op();
    send_beat(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  function automatic logic [63:0] rand_operand(input logic [2:0] op);
    logic [63:0] x, d;
    x = {$urandom, $urandom};
    d = {1'($urandom), 11'($urandom_range(760, 1100)), x[51:0]};
    case ($urandom_range(5))
      0: return x;
      1: return {4'($urandom), x[59:0]};
      2: return {{3{x[63]}}, x[60:0]};
      3: return d;
      4: return {4'h8, d[63:4]};
      default: return (op == OP_BOX_INT) ? 64'($signed(32'($urandom))) : {4'h1, x[59:0]};
    endcase
  endfunction

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    logic [2:0] op;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_beat(op, rand_operand(op));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_classify();
    test_box_int();
    test_box_real();
    test_unbox_tags();
    test_convert();
    test_bad_op();
    test_random(360, 0, 0);
    test_random(360, 73, 0);
    test_random(360, 0, 73);
    test_random(360, 37, 37);
    go_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Overall time limit.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
